// ===== hw/rtl/xeu_pkg.sv =====
// Shared types and constants for the XML entity unescape block.
package xeu_pkg;

  // Characters that drive entity matching
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChApos  = 8'h27;  // '\''
  localparam logic [7:0] ChQuot  = 8'h22;  // '"'
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowG  = 8'h67;
  localparam logic [7:0] ChLowL  = 8'h6C;
  localparam logic [7:0] ChLowM  = 8'h6D;
  localparam logic [7:0] ChLowO  = 8'h6F;
  localparam logic [7:0] ChLowP  = 8'h70;
  localparam logic [7:0] ChLowQ  = 8'h71;
  localparam logic [7:0] ChLowS  = 8'h73;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowU  = 8'h75;

  // Queue between the matcher and the output stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       malformed;
  } result_t;

endpackage

// ===== hw/rtl/xeu_front.sv =====
// Front end: accepts raw bytes and tracks progress through an entity.
module xeu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output xeu_pkg::result_t push_data_o
);
  import xeu_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE = 17'b0_0000_0000_0000_0001,
    ST_AND  = 17'b0_0000_0000_0000_0010,
    ST_A    = 17'b0_0000_0000_0000_0100,
    ST_AM   = 17'b0_0000_0000_0000_1000,
    ST_AMP  = 17'b0_0000_0000_0001_0000,
    ST_AP   = 17'b0_0000_0000_0010_0000,
    ST_APO  = 17'b0_0000_0000_0100_0000,
    ST_APOS = 17'b0_0000_0000_1000_0000,
    ST_L    = 17'b0_0000_0001_0000_0000,
    ST_LT   = 17'b0_0000_0010_0000_0000,
    ST_G    = 17'b0_0000_0100_0000_0000,
    ST_GT   = 17'b0_0000_1000_0000_0000,
    ST_Q    = 17'b0_0001_0000_0000_0000,
    ST_QU   = 17'b0_0010_0000_0000_0000,
    ST_QUO  = 17'b0_0100_0000_0000_0000,
    ST_QUOT = 17'b0_1000_0000_0000_0000,
    ST_DROP = 17'b1_0000_0000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  state_e     adv_state;
  logic       adv_ok;
  logic       close_ok;
  logic [7:0] close_byte;
  logic       is_idle;
  logic       is_drop;
  logic       accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Classify the current state against the incoming byte
  always_comb begin
    adv_state  = ST_IDLE;
    adv_ok     = 1'b0;
    close_ok   = 1'b0;
    close_byte = 8'h00;
    is_idle    = 1'b0;
    is_drop    = 1'b0;
    case (state_q)
      ST_AND: begin
        if (in_byte_i == ChLowA) begin
          adv_state = ST_A; adv_ok = 1'b1;
        end else if (in_byte_i == ChLowL) begin
          adv_state = ST_L; adv_ok = 1'b1;
        end else if (in_byte_i == ChLowG) begin
          adv_state = ST_G; adv_ok = 1'b1;
        end else if (in_byte_i == ChLowQ) begin
          adv_state = ST_Q; adv_ok = 1'b1;
        end
      end
      ST_A: begin
        if (in_byte_i == ChLowM) begin
          adv_state = ST_AM; adv_ok = 1'b1;
        end else if (in_byte_i == ChLowP) begin
          adv_state = ST_AP; adv_ok = 1'b1;
        end
      end
      ST_AM: begin
        adv_state = ST_AMP; adv_ok = (in_byte_i == ChLowP);
      end
      ST_AP: begin
        adv_state = ST_APO; adv_ok = (in_byte_i == ChLowO);
      end
      ST_APO: begin
        adv_state = ST_APOS; adv_ok = (in_byte_i == ChLowS);
      end
      ST_L: begin
        adv_state = ST_LT; adv_ok = (in_byte_i == ChLowT);
      end
      ST_G: begin
        adv_state = ST_GT; adv_ok = (in_byte_i == ChLowT);
      end
      ST_Q: begin
        adv_state = ST_QU; adv_ok = (in_byte_i == ChLowU);
      end
      ST_QU: begin
        adv_state = ST_QUO; adv_ok = (in_byte_i == ChLowO);
      end
      ST_QUO: begin
        adv_state = ST_QUOT; adv_ok = (in_byte_i == ChLowT);
      end
      ST_AMP: begin
        close_ok = 1'b1; close_byte = ChAmp;
      end
      ST_APOS: begin
        close_ok = 1'b1; close_byte = ChApos;
      end
      ST_LT: begin
        close_ok = 1'b1; close_byte = ChLt;
      end
      ST_GT: begin
        close_ok = 1'b1; close_byte = ChGt;
      end
      ST_QUOT: begin
        close_ok = 1'b1; close_byte = ChQuot;
      end
      ST_DROP: is_drop = 1'b1;
      default: is_idle = 1'b1;  // idle and any stray code
    endcase
  end

  // Next state and result for an accepted byte
  always_comb begin
    state_d     = state_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      if (is_drop) begin
        state_d = in_last_i ? ST_IDLE : ST_DROP;
      end else if (is_idle) begin
        if (in_byte_i != ChAmp) begin
          push_o      = 1'b1;
          push_data_o = '{data: in_byte_i, last: in_last_i, malformed: 1'b0};
          state_d     = ST_IDLE;
        end else if (in_last_i) begin
          push_o      = 1'b1;
          push_data_o = '{data: 8'h00, last: 1'b1, malformed: 1'b1};
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_AND;
        end
      end else if (in_byte_i == ChSemi && close_ok) begin
        push_o      = 1'b1;
        push_data_o = '{data: close_byte, last: in_last_i, malformed: 1'b0};
        state_d     = ST_IDLE;
      end else if (adv_ok && !in_last_i) begin
        state_d = adv_state;
      end else begin
        // Unknown or unfinished entity: one error result, then drop the rest of the string unless this byte ends it
        push_o      = 1'b1;
        push_data_o = '{data: 8'h00, last: 1'b1, malformed: 1'b1};
        state_d     = in_last_i ? ST_IDLE : ST_DROP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/xeu_queue.sv =====
// Short result queue between the matcher and the output stage.
module xeu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xeu_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output xeu_pkg::result_t head_o
);
  import xeu_pkg::*;

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = QCntW'(count_q + 1'b1);
    end else if (!do_push && do_pop) begin
      count_d = QCntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/xeu_back.sv =====
// Back end: output register that drives the result stream.
module xeu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  xeu_pkg::result_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output xeu_pkg::result_t out_data_o
);
  import xeu_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // Refill whenever the register is empty or being drained
  assign q_pop_o = q_valid_i & (~valid_q | out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/xml_entity_unescape.sv =====
// Top level of the XML predefined entity decoder.
//
// Decodes &amp; &lt; &gt; &apos; and &quot; in a byte stream into single
// bytes and passes every other byte through; tlast marks the end of each
// string. The matcher takes one byte per clock, every clock, as long as its
// four-entry result queue has room; results leave through a registered
// output stage, also one per clock while m_axis_tready_i is high, so a
// full-rate stream flows without bubbles through queue and output register.
// Bytes inside an entity give no transfer until the closing ';'. An unknown
// or unfinished entity gives a single transfer with tdata zero, tuser high
// and tlast high; the remaining input bytes of that string, up to and
// including its last one, are consumed without output.
module xml_entity_unescape (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // out_last
  output logic       m_axis_tuser_o    // [0] malformed
);
  import xeu_pkg::*;

  logic    q_full;
  logic    push;
  result_t push_data;
  logic    pop;
  logic    q_valid;
  result_t q_head;
  result_t out_data;

  // Entity matcher
  xeu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue
  xeu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Output stage
  xeu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data.data;
  assign m_axis_tlast_o = out_data.last;
  assign m_axis_tuser_o = out_data.malformed;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the XML predefined entity decoder.
module testbench;
  import xeu_pkg::*;

  localparam int unsigned TotalBytes = 1250;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned NumPhases  = 6;

  // Position inside an entity name; MIdle doubles as "no edge" for next_match
  typedef enum logic [4:0] {
    MIdle, MAnd, MA, MAm, MAmp, MAp, MApo, MApos,
    ML, MLt, MG, MGt, MQ, MQu, MQuo, MQuot, MDrop
  } match_e;

  // Predicts decoded transfers from accepted input and checks the output stream
  class entity_scoreboard;
    match_e      cur;
    result_t     decoded_q[$];
    int unsigned live_bytes;
    int unsigned errors;

    function new();
      cur        = MIdle;
      live_bytes = 0;
      errors     = 0;
    endfunction

    function void expect_out(logic [7:0] d, logic l, logic bad);
      result_t r;
      r.data      = d;
      r.last      = l;
      r.malformed = bad;
      decoded_q.push_back(r);
    endfunction

    // Successor for byte c, MIdle when c breaks the entity
    function match_e next_match(match_e s, logic [7:0] c);
      case (s)
        MAnd: begin
          if (c == ChLowA) return MA;
          if (c == ChLowL) return ML;
          if (c == ChLowG) return MG;
          if (c == ChLowQ) return MQ;
          return MIdle;
        end
        MA: begin
          if (c == ChLowM) return MAm;
          if (c == ChLowP) return MAp;
          return MIdle;
        end
        MAm:  return (c == ChLowP) ? MAmp  : MIdle;
        MAp:  return (c == ChLowO) ? MApo  : MIdle;
        MApo: return (c == ChLowS) ? MApos : MIdle;
        ML:   return (c == ChLowT) ? MLt   : MIdle;
        MG:   return (c == ChLowT) ? MGt   : MIdle;
        MQ:   return (c == ChLowU) ? MQu   : MIdle;
        MQu:  return (c == ChLowO) ? MQuo  : MIdle;
        MQuo: return (c == ChLowT) ? MQuot : MIdle;
        default: return MIdle;
      endcase
    endfunction

    // Called on every accepted input transfer
    function void note_byte(logic [7:0] c, logic l);
      logic [7:0] closed;
      match_e     nx;
      // rest of a malformed string is swallowed
      if (cur == MDrop) begin
        if (l) cur = MIdle;
        return;
      end
      live_bytes++;
      if (cur == MIdle) begin
        if (c != ChAmp) expect_out(c, l, 1'b0);
        else if (l) expect_out(8'h00, 1'b1, 1'b1);
        else cur = MAnd;
        return;
      end
      case (cur)
        MAmp:    closed = ChAmp;
        MApos:   closed = ChApos;
        MLt:     closed = ChLt;
        MGt:     closed = ChGt;
        MQuot:   closed = ChQuot;
        default: closed = 8'h00;
      endcase
      if (c == ChSemi && closed != 8'h00) begin
        expect_out(closed, l, 1'b0);
        cur = MIdle;
        return;
      end
      nx = next_match(cur, c);
      if (nx != MIdle && !l) begin
        cur = nx;
        return;
      end
      // unknown or unfinished entity
      expect_out(8'h00, 1'b1, 1'b1);
      cur = l ? MIdle : MDrop;
    endfunction

    // Called on every accepted output transfer
    function void check_result(logic [7:0] d, logic l, logic bad);
      result_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: data %02h last %0b malformed %0b", d, l, bad);
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== d || want.last !== l || want.malformed !== bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected data %02h last %0b malformed %0b, got %02h %0b %0b",
                   want.data, want.last, want.malformed, d, l, bad);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] in_byte
  logic       s_axis_tlast_i;   // in_last
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;   // out_last
  logic       m_axis_tuser_o;   // [0] malformed

  xml_entity_unescape dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  entity_scoreboard sb = new();
  string      ent_name [5] = '{"amp", "lt", "gt", "apos", "quot"};
  logic [7:0] text_q[$];
  bit         tx_gaps;
  bit         rx_gaps;
  bit         rx_hold;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Letter taken from one of the entity names
  function automatic logic [7:0] name_letter();
    int unsigned k;
    k = $urandom_range(0, 4);
    return ent_name[k][$urandom_range(0, ent_name[k].len() - 1)];
  endfunction

  function automatic logic [7:0] plain_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return ChSemi;
    if (r == 1) return ChAmp;
    if (r < 4) return name_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  // Sample both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    end
  end

  // Output side back-pressure, with one long hold on request
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned g;
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      g = pick_gap(rx_gaps);
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // One input transfer; entered and left at a rising edge
  task automatic push_byte(input logic [7:0] b, input logic l);
    int unsigned g;
    g = pick_gap(tx_gaps);
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= l;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Send text_q as one string, tlast on its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      push_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_entity(input int unsigned k, input int unsigned n, input bit close);
    text_q.push_back(ChAmp);
    for (int j = 0; j < n; j++) text_q.push_back(ent_name[k][j]);
    if (close) text_q.push_back(ChSemi);
  endtask

  // Random string: plain bytes, whole entities and broken ones
  task automatic build_text();
    int unsigned segs, k, kind;
    segs = $urandom_range(1, 8);
    for (int i = 0; i < segs; i++) begin
      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, 4);
      if (kind < 50) begin
        text_q.push_back(plain_byte());
      end else if (kind < 85) begin
        add_entity(k, ent_name[k].len(), 1'b1);
      end else begin
        add_entity(k, $urandom_range(0, ent_name[k].len() - 1), 1'b0);
        // a broken entity at the string end may stay unfinished
        if (i != segs - 1 || $urandom_range(0, 1)) text_q.push_back(plain_byte());
      end
    end
  endtask

  // Let the last accepted transfer be noted before waiting for results
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    tx_gaps         = 1'b0;
    rx_gaps         = 1'b0;
    rx_hold         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, entities, unknown/unfinished entities, drop phase
    push_byte(8'h00, 1'b0);
    add_entity(1, 2, 1'b1);
    add_entity(3, 4, 1'b1);
    send_text();
    text_q = '{ChAmp, 8'h78, 8'h79, ChSemi};
    send_text();
    push_byte(ChAmp, 1'b1);
    text_q = '{ChAmp, ChLowQ};
    send_text();
    text_q = '{ChAmp, 8'h7A};
    send_text();
    text_q = '{8'h00, 8'hFF};
    send_text();
    add_entity(2, 2, 1'b1);
    send_text();
    drain();

    // Random phases with different idling mixes
    for (int p = 0; p < NumPhases; p++) begin
      tx_gaps = (p == 1 || p >= 4);
      rx_gaps = (p == 2 || p >= 4);
      if (p == 3) begin
        // stall the output for a long stretch while input keeps coming
        rx_hold = 1'b1;
        for (int i = 0; i < 40; i++) push_byte(plain_byte() ^ 8'h80, i == 39);
      end
      while (sb.live_bytes < TotalBytes * (p + 1) / NumPhases) begin
        build_text();
        send_text();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
